/* rtl/plist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CMD_W  = 4;
    localparam int WORD_W = 32;
    localparam int POS_W  = 8;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_HEAD  = 4'd0,
        CMD_ADD_TAIL  = 4'd1,
        CMD_INSERT    = 4'd2,
        CMD_DROP_HEAD = 4'd3,
        CMD_DROP_TAIL = 4'd4,
        CMD_DELETE    = 4'd5,
        CMD_GET_HEAD  = 4'd6,
        CMD_GET_TAIL  = 4'd7,
        CMD_GET_AT    = 4'd8
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  at;
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [ST_W-1:0]   status;
        logic [LEN_W-1:0]  length;
    } t_rsp;

endpackage
`default_nettype wire

/* rtl/plist_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_if
// Command and response channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface plist_cmd_if;
    import plist_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface plist_rsp_if;
    import plist_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_value;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  length;

    modport source (output valid, read_value, status, length, input ready);
    modport sink   (input valid, read_value, status, length, output ready);
endinterface
`default_nettype wire

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH words held in a chain of cells, front in cell 0.
//
//   channel  dir  payload                         word accepted when
//   i_cmd    in   command, value, position        valid && ready
//   o_rsp    out  read_value, status, length      valid && ready
//
// One command per cycle while ready is high; every cell shifts, loads or holds in that cycle.
// The response is registered into a two-word buffer: output word, then skid word.
// Ready is low in reset and while the second buffer word is held; it rises
// the cycle after the sink takes a word.
// Reset clears the entry count and the buffer; the cells are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plist_cmd_if.sink   i_cmd,
    plist_rsp_if.source o_rsp
);
    import plist_pkg::*;

    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_rd   [DEPTH];
    logic [WORD_W-1:0] rd_or;

    t_cell_ctl ctl;
    logic      rd_hit;
    t_status   status;
    logic [LEN_W-1:0] length;
    logic      ready;
    logic      fire;
    t_rsp      rsp_new;

    logic r_out_valid;
    logic n_out_valid;
    logic r_skid_valid;
    logic n_skid_valid;
    t_rsp r_out;
    t_rsp n_out;
    t_rsp r_skid;
    t_rsp n_skid;

    assign ready       = i_rst_n && !r_skid_valid;
    assign fire        = i_cmd.valid && ready;
    assign i_cmd.ready = ready;

    plist_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_command  (i_cmd.command),
        .i_value    (i_cmd.value),
        .i_position (i_cmd.position),
        .o_ctl      (ctl),
        .o_rd_hit   (rd_hit),
        .o_status   (status),
        .o_length   (length)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] prev_word;
        logic [WORD_W-1:0] next_word;

        if (k == 0) begin : g_first
            assign prev_word = '0;
        end else begin : g_prev
            assign prev_word = w_word[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign next_word = w_word[k];
        end else begin : g_next
            assign next_word = w_word[k+1];
        end

        plist_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (POS_W'(k)),
            .i_ctl       (ctl),
            .i_prev_word (prev_word),
            .i_next_word (next_word),
            .o_word      (w_word[k]),
            .o_rd_word   (w_rd[k])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | w_rd[k];
        end
    end

    always_comb begin
        rsp_new.read_value = rd_hit ? rd_or : ALL_ONES;
        rsp_new.status     = status;
        rsp_new.length     = length;
    end

    // two-word response buffer
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_out_valid && o_rsp.ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (fire) begin
                n_out = rsp_new;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (fire) begin
            if (!r_out_valid) begin
                n_out       = rsp_new;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = rsp_new;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.length     = r_out.length;

endmodule
`default_nettype wire

/* rtl/plist_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cell
// One list cell: holds a word, takes its own, a neighbour's or the new word.
// ----------------------------------------------------------------------------
module plist_cell (
    input  logic                          i_clk,
    input  logic [plist_pkg::POS_W-1:0]   i_index,
    input  plist_pkg::t_cell_ctl          i_ctl,
    input  logic [plist_pkg::WORD_W-1:0]  i_prev_word,
    input  logic [plist_pkg::WORD_W-1:0]  i_next_word,
    output logic [plist_pkg::WORD_W-1:0]  o_word,
    output logic [plist_pkg::WORD_W-1:0]  o_rd_word
);
    import plist_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            CELL_OPEN: begin
                if (i_index == i_ctl.at) begin
                    n_word = i_ctl.word;
                end else if (i_index > i_ctl.at) begin
                    n_word = i_prev_word;
                end
            end
            CELL_CLOSE: begin
                if (i_index >= i_ctl.at) begin
                    n_word = i_next_word;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    assign o_rd_word = (i_index == i_ctl.at) ? r_word : '0;

endmodule
`default_nettype wire

/* rtl/plist_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_ctrl
// Command decode, entry count and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
module plist_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [plist_pkg::CMD_W-1:0]   i_command,
    input  logic [plist_pkg::WORD_W-1:0]  i_value,
    input  logic [plist_pkg::POS_W-1:0]   i_position,
    output plist_pkg::t_cell_ctl          o_ctl,
    output logic                          o_rd_hit,
    output plist_pkg::t_status            o_status,
    output logic [plist_pkg::LEN_W-1:0]   o_length
);
    import plist_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = POS_W + 1;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [EXT_W-1:0] cnt_x;
    logic [EXT_W-1:0] pos_x;
    logic [EXT_W-1:0] at_x;
    logic [EXT_W-1:0] nxt_x;
    logic             full;
    logic             empty;
    t_cell_op         op;
    t_status          st;
    logic             hit;

    assign cnt_x = EXT_W'(r_count);
    assign pos_x = EXT_W'(i_position);
    assign full  = (cnt_x == EXT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        op    = CELL_HOLD;
        at_x  = '0;
        st    = ST_IGNORED;
        hit   = 1'b0;
        nxt_x = cnt_x;
        unique case (i_command) inside
            CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_INSERT: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    if (i_command == CMD_ADD_HEAD) begin
                        at_x = '0;
                    end else if (i_command == CMD_ADD_TAIL) begin
                        at_x = cnt_x;
                    end else begin
                        at_x = pos_x;
                    end
                    if (at_x <= cnt_x) begin
                        op    = CELL_OPEN;
                        st    = ST_DONE;
                        nxt_x = cnt_x + EXT_W'(1);
                    end
                end
            end
            CMD_DROP_HEAD, CMD_DROP_TAIL, CMD_DELETE: begin
                if (i_command == CMD_DROP_HEAD) begin
                    at_x = '0;
                end else if (i_command == CMD_DROP_TAIL) begin
                    at_x = cnt_x - EXT_W'(1);
                end else begin
                    at_x = pos_x;
                end
                if (!empty && at_x < cnt_x) begin
                    op    = CELL_CLOSE;
                    st    = ST_DONE;
                    nxt_x = cnt_x - EXT_W'(1);
                end
            end
            CMD_GET_HEAD, CMD_GET_TAIL, CMD_GET_AT: begin
                if (i_command == CMD_GET_HEAD) begin
                    at_x = '0;
                end else if (i_command == CMD_GET_TAIL) begin
                    at_x = cnt_x - EXT_W'(1);
                end else begin
                    at_x = pos_x;
                end
                if (!empty && at_x < cnt_x) begin
                    hit = 1'b1;
                    st  = ST_DONE;
                end
            end
            default: st = ST_IGNORED;
        endcase
    end

    always_comb begin
        o_ctl.op   = i_fire ? op : CELL_HOLD;
        o_ctl.at   = at_x[POS_W-1:0];
        o_ctl.word = i_value;
        o_rd_hit   = hit;
        o_status   = st;
        o_length   = nxt_x[LEN_W-1:0];
        n_count    = i_fire ? nxt_x[CNT_W-1:0] : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/plist_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_chk
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module plist_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [plist_pkg::WORD_W-1:0]  i_rsp_read_value,
    input logic [plist_pkg::ST_W-1:0]    i_rsp_status,
    input logic [plist_pkg::LEN_W-1:0]   i_rsp_length
);
    import plist_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_read_value)
            && $stable(i_rsp_status) && $stable(i_rsp_length))
        else $error("response word changed while stalled");

    a_miss_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_DONE |-> i_rsp_read_value == ALL_ONES)
        else $error("refused command returned data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_ready |-> i_rsp_valid && $past(i_rsp_valid && !i_rsp_ready))
        else $error("command refused with no response pending");

    a_cmd_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> i_rsp_valid)
        else $error("accepted command gave no response");

endmodule

bind positional_list_engine plist_chk u_plist_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_read_value (o_rsp.read_value),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_length     (o_rsp.length)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives list commands into positional_list_engine and checks every response
// word against a queue-based shadow of the list. A directed table covers empty,
// full and out-of-range cases first. Random traffic then swings the list
// between empty and full over four phases idling none, sender, receiver, both.
// ----------------------------------------------------------------------------
module testbench;
    import plist_pkg::*;

    localparam int LIST_DEPTH    = 16;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 414;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 4'd9;
    localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 4'hF;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] val;
        logic [POS_W-1:0]  pos;
        logic [4:0]        reps;
        logic              typed;
        t_rsp              rsp;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    plist_cmd_if cmd_if ();
    plist_rsp_if rsp_if ();

    positional_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    logic [WORD_W-1:0] shadow_list [$];
    t_rsp              pending_rsp [$];
    t_stim_row         directed_rows [DIRECTED_ROWS];
    int                sender_idle_pct;
    int                receiver_stall_pct;
    bit                failed;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("positional_list_engine verification failed");
        $finish;
    end

    function automatic t_rsp apply_list_command(logic [CMD_W-1:0] cmd,
                                                logic [WORD_W-1:0] val,
                                                logic [POS_W-1:0] pos);
        t_rsp r;
        int   slot;
        r.read_value = ALL_ONES;
        r.status     = ST_DONE;
        case (cmd)
            CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_INSERT: begin
                if (shadow_list.size() >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (cmd == CMD_ADD_HEAD) begin
                    shadow_list.insert(0, val);
                end else if (cmd == CMD_ADD_TAIL) begin
                    shadow_list.insert(shadow_list.size(), val);
                end else if (int'(pos) > shadow_list.size()) begin
                    r.status = ST_IGNORED;
                end else begin
                    shadow_list.insert(int'(pos), val);
                end
            end
            CMD_DROP_HEAD, CMD_DROP_TAIL: begin
                if (shadow_list.size() == 0) begin
                    r.status = ST_IGNORED;
                end else if (cmd == CMD_DROP_HEAD) begin
                    shadow_list.delete(0);
                end else begin
                    shadow_list.delete(shadow_list.size() - 1);
                end
            end
            CMD_DELETE: begin
                if (int'(pos) >= shadow_list.size()) begin
                    r.status = ST_IGNORED;
                end else begin
                    shadow_list.delete(int'(pos));
                end
            end
            CMD_GET_HEAD, CMD_GET_TAIL, CMD_GET_AT: begin
                slot = (cmd == CMD_GET_HEAD) ? 0 :
                       (cmd == CMD_GET_TAIL) ? shadow_list.size() - 1 : int'(pos);
                if (shadow_list.size() == 0 || slot >= shadow_list.size()) begin
                    r.status = ST_IGNORED;
                end else begin
                    r.read_value = shadow_list[slot];
                end
            end
            default: begin
                r.status = ST_IGNORED;
            end
        endcase
        r.length = LEN_W'(shadow_list.size());
        return r;
    endfunction

    // one command word; gaps drawn before it while the sender idles
    task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                              input logic [POS_W-1:0] pos, output t_rsp predicted);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= cmd;
        cmd_if.value    <= val;
        cmd_if.position <= pos;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = apply_list_command(cmd, val, pos);
    endtask

    function automatic void check_field(string name, logic [WORD_W-1:0] expected_val,
                                        logic [WORD_W-1:0] actual_val);
        if (expected_val !== actual_val) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name,
                     expected_val, actual_val);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_rsp oldest;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t unexpected response word expected none actual %h %h %h",
                         $time, rsp_if.read_value, rsp_if.status, rsp_if.length);
                failed = 1'b1;
            end else begin
                oldest = pending_rsp[0];
                pending_rsp.delete(0);
                check_field("read_value", oldest.read_value, rsp_if.read_value);
                check_field("status", WORD_W'(oldest.status), WORD_W'(rsp_if.status));
                check_field("length", WORD_W'(oldest.length), WORD_W'(rsp_if.length));
            end
        end
    end

    initial begin
        t_rsp              predicted;
        t_stim_row         row;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] val;
        logic [POS_W-1:0]  pos;
        int                sent_items;
        int                phase;
        int                len;
        int                grow_pct;
        int                shrink_pct;
        int                k;
        int                m;
        bit                filling;

        failed             = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n         <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.command  <= CMD_ADD_HEAD;
        cmd_if.value    <= '0;
        cmd_if.position <= '0;

        directed_rows = '{
            '{CMD_DROP_HEAD,  32'h0,         8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd0}},
            '{CMD_DROP_TAIL,  32'h0,         8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd0}},
            '{CMD_GET_TAIL,   32'h0,         8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd0}},
            '{CMD_DELETE,     32'h0,         8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd0}},
            '{CMD_INSERT,     32'h1,         8'd1,   5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd0}},
            '{CMD_INSERT,     32'h0,         8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_DONE, 5'd1}},
            '{CMD_ADD_HEAD,   ALL_ONES,      8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_DONE, 5'd2}},
            '{CMD_ADD_TAIL,   32'h8000_0001, 8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_DONE, 5'd3}},
            '{CMD_GET_HEAD,   32'h0,         8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_DONE, 5'd3}},
            '{CMD_GET_AT,     32'h0,         8'hFF,  5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd3}},
            '{CMD_LAST_CODE,  ALL_ONES,      8'hFF,  5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd3}},
            '{CMD_ADD_TAIL,   32'h0,         8'd0,   5'd13, 1'b0, '0},
            '{CMD_ADD_HEAD,   32'h1234_5678, 8'd0,   5'd1,  1'b1, '{ALL_ONES, ST_FULL, 5'd16}},
            '{CMD_INSERT,     32'h1234_5678, 8'd16,  5'd1,  1'b1, '{ALL_ONES, ST_FULL, 5'd16}},
            '{CMD_GET_AT,     32'h0,         8'd15,  5'd1,  1'b0, '0},
            '{CMD_GET_AT,     32'h0,         8'd16,  5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd16}},
            '{CMD_DELETE,     32'h0,         8'd16,  5'd1,  1'b1, '{ALL_ONES, ST_IGNORED, 5'd16}},
            '{CMD_DELETE,     32'h0,         8'd15,  5'd1,  1'b0, '0},
            '{CMD_DROP_TAIL,  32'h0,         8'd0,   5'd1,  1'b0, '0},
            '{CMD_DROP_HEAD,  32'h0,         8'd0,   5'd1,  1'b0, '0},
            '{CMD_INSERT,     32'h5A5A_5A5A, 8'd13,  5'd1,  1'b0, '0},
            '{CMD_GET_TAIL,   32'h0,         8'd0,   5'd1,  1'b0, '0},
            '{CMD_DELETE,     32'h0,         8'd0,   5'd1,  1'b0, '0},
            '{CMD_GET_AT,     32'h0,         8'd1,   5'd1,  1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (int n = 0; n < int'(row.reps); n++) begin
                val = (row.reps > 1) ? WORD_W'($urandom()) : row.val;
                issue_word(row.cmd, val, row.pos, predicted);
                pending_rsp.insert(pending_rsp.size(), row.typed ? row.rsp : predicted);
            end
        end

        // random traffic, list swung between empty and full
        sent_items = 0;
        filling    = 1'b1;
        while (sent_items < RANDOM_ITEMS) begin
            phase = sent_items * 4 / RANDOM_ITEMS;
            sender_idle_pct    = (phase == 1) ? 63 : (phase == 3) ? 38 : 0;
            receiver_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 38 : 0;

            len = shadow_list.size();
            if (len >= LIST_DEPTH && $urandom_range(3) == 0) begin
                filling = 1'b0;
            end else if (len == 0 && $urandom_range(3) == 0) begin
                filling = 1'b1;
            end
            grow_pct   = filling ? 55 : 20;
            shrink_pct = filling ? 20 : 55;

            k = $urandom_range(99);
            if (k < 4) begin
                cmd = CMD_W'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
            end else if (k < 4 + grow_pct) begin
                cmd = CMD_W'($urandom_range(CMD_INSERT, CMD_ADD_HEAD));
            end else if (k < 4 + grow_pct + shrink_pct) begin
                cmd = CMD_W'($urandom_range(CMD_DELETE, CMD_DROP_HEAD));
            end else begin
                cmd = CMD_W'($urandom_range(CMD_GET_AT, CMD_GET_HEAD));
            end

            m = $urandom_range(19);
            if (m == 0) begin
                pos = POS_W'($urandom());
            end else if (m == 1) begin
                pos = POS_W'(len + 1);
            end else begin
                pos = POS_W'($urandom_range(len));
            end

            m = $urandom_range(15);
            val = (m == 0) ? '0 : (m == 1) ? ALL_ONES : WORD_W'($urandom());

            issue_word(cmd, val, pos, predicted);
            pending_rsp.insert(pending_rsp.size(), predicted);
            sent_items++;
        end

        cmd_if.valid       <= 1'b0;
        receiver_stall_pct = 0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!failed && pending_rsp.size() == 0) begin
            $display("positional_list_engine verification clean");
        end else begin
            $display("positional_list_engine verification failed");
        end
        $finish;
    end

endmodule
